// ----- src/tpas_pkg.sv -----
`timescale 1ns / 1ps
package tpas_pkg;

    localparam int DW      = 32;              // field and register width
    localparam int NUM_W   = 96;              // discriminant numerator magnitude
    localparam int SUM_W   = 98;              // signed numerator before the sign fix
    localparam int REM_W   = DW + 1;          // divider remainder
    localparam int DIV_N   = NUM_W;           // one quotient bit per stage
    localparam int ROOT_W  = NUM_W / 2;       // integer square root width
    localparam int SQR_N   = ROOT_W;          // one root bit per stage
    localparam int SRM_W   = ROOT_W + 2;      // square-root remainder
    localparam int P_W     = ROOT_W + 3;      // v0 +/- s, v1 +/- s
    localparam int LHS_W   = P_W + 11;        // -1000 * p
    localparam int IN_TDW  = 3 * DW;
    localparam int OUT_TDW = DW;
    localparam int OUT_TUW = 2;

    localparam logic signed [11:0] T0_SCALE = 12'sd1000;  // t0 < 1/1000

    localparam logic [0:0] REG_ACCEL_FIRST  = 1'b0;
    localparam logic [0:0] REG_ACCEL_SECOND = 1'b1;

    // values that ride alongside the arithmetic of every stage up to the root select
    typedef struct packed {
        logic signed [DW-1:0] v0;
        logic signed [DW-1:0] v1;
        logic                 neg;
    } t_side;

endpackage

// ----- src/two_phase_accel_selector.sv -----
`timescale 1ns / 1ps
// Two-phase acceleration selector.
// Input channel (s_axis): one transfer per query carrying speed_now,
// speed_goal and distance, all signed Q16.16. Output channel (m_axis): one
// transfer per query with the selected acceleration in tdata and the flags
// use_second and degenerate in tuser.
// The two accelerations are set through i_cfg_we / i_cfg_idx / i_cfg_data;
// write them only while no query is in flight.
// From input transfer to result a query passes four product and sum
// stages, one sign-fix stage, 96 restoring divider stages (one quotient bit
// each), 48 square-root stages (one root bit each), a root-select stage and
// the output register. Throughput is one query per cycle unless the receiver stalls.
// Reset clears every valid bit and loads a0 = 1.0, a1 = -1.0.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and s_axis_tready drops; nothing is lost or repeated, and bubbles in the
// pipeline still advance only while the output is free or being taken.
module two_phase_accel_selector
    import tpas_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    // [31:0] speed_now, [63:32] speed_goal, [95:64] distance
    input  logic [IN_TDW-1:0]  s_axis_tdata,
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    // [31:0] accel_out
    output logic [OUT_TDW-1:0] m_axis_tdata,
    // [0] use_second, [1] degenerate
    output logic [OUT_TUW-1:0] m_axis_tuser,
    input  logic               i_cfg_we,
    input  logic [0:0]         i_cfg_idx,
    input  logic [DW-1:0]      i_cfg_data
);

    logic signed [DW-1:0] r_accel_first, r_accel_second;
    logic w_en;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accel_first  <= 32'sh0001_0000;
            r_accel_second <= 32'shFFFF_0000;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_ACCEL_FIRST:  r_accel_first  <= i_cfg_data;
                REG_ACCEL_SECOND: r_accel_second <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // advance the whole pipeline unless a finished result is held back
    assign w_en          = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = w_en;

    // configuration-only terms; stable while queries are in flight
    logic              w_cfg_deg;
    logic signed [DW:0] w_m;
    logic              w_m_neg;
    logic [REM_W-1:0]  w_m_mag;
    assign w_cfg_deg = (r_accel_first == '0) || (r_accel_second == '0)
                     || (r_accel_first == r_accel_second);
    assign w_m     = {r_accel_second[DW-1], r_accel_second}
                   - {r_accel_first[DW-1], r_accel_first};
    assign w_m_neg = w_m[DW];
    assign w_m_mag = w_m_neg ? REM_W'(-w_m) : REM_W'(w_m);

    // ---------------- stage 1: first products ----------------
    logic                   r1_vld;
    t_side                  r1_sd;
    logic signed [DW-1:0]   r1_d;
    logic signed [2*DW-1:0] r1_a1v0, r1_a0v1, r1_a0a1;
    t_side                  n1_sd;
    assign n1_sd.v0  = s_axis_tdata[DW-1:0];
    assign n1_sd.v1  = s_axis_tdata[2*DW-1:DW];
    assign n1_sd.neg = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r1_vld <= 1'b0;
        else if (w_en) r1_vld <= s_axis_tvalid;
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_sd   <= n1_sd;
            r1_d    <= s_axis_tdata[3*DW-1:2*DW];
            r1_a1v0 <= r_accel_second * n1_sd.v0;
            r1_a0v1 <= r_accel_first * n1_sd.v1;
            r1_a0a1 <= r_accel_first * r_accel_second;
        end
    end

    // ---------------- stage 2: split 64 x 32 products ----------------
    logic                 r2_vld;
    t_side                r2_sd;
    logic signed [2*DW-1:0] r2_h1, r2_h2, r2_h3;
    logic signed [2*DW:0]   r2_l1, r2_l2, r2_l3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r2_vld <= 1'b0;
        else if (w_en) r2_vld <= r1_vld;
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_sd <= r1_sd;
            r2_h1 <= $signed(r1_a1v0[2*DW-1:DW]) * r1_sd.v0;
            r2_l1 <= $signed({1'b0, r1_a1v0[DW-1:0]}) * r1_sd.v0;
            r2_h2 <= $signed(r1_a0v1[2*DW-1:DW]) * r1_sd.v1;
            r2_l2 <= $signed({1'b0, r1_a0v1[DW-1:0]}) * r1_sd.v1;
            r2_h3 <= $signed(r1_a0a1[2*DW-1:DW]) * r1_d;
            r2_l3 <= $signed({1'b0, r1_a0a1[DW-1:0]}) * r1_d;
        end
    end

    // ---------------- stage 3: join partial products ----------------
    logic                    r3_vld;
    t_side                   r3_sd;
    logic signed [NUM_W-1:0] r3_t1, r3_t2, r3_t3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r3_vld <= 1'b0;
        else if (w_en) r3_vld <= r2_vld;
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r3_sd <= r2_sd;
            r3_t1 <= $signed({r2_h1, 32'b0}) + $signed({{(DW-1){r2_l1[2*DW]}}, r2_l1});
            r3_t2 <= $signed({r2_h2, 32'b0}) + $signed({{(DW-1){r2_l2[2*DW]}}, r2_l2});
            r3_t3 <= $signed({r2_h3, 32'b0}) + $signed({{(DW-1){r2_l3[2*DW]}}, r2_l3});
        end
    end

    // ---------------- stage 4: numerator sum ----------------
    logic                    r4_vld;
    t_side                   r4_sd;
    logic signed [SUM_W-1:0] r4_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r4_vld <= 1'b0;
        else if (w_en) r4_vld <= r3_vld;
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r4_sd <= r3_sd;
            r4_n  <= SUM_W'(r3_t1) - SUM_W'(r3_t2) + (SUM_W'(r3_t3) <<< 1);
        end
    end

    // ---------------- stage 5: sign fix, feeds divider ----------------
    logic               r_dv_vld [DIV_N+1];
    t_side              r_dv_sd  [DIV_N+1];
    logic [REM_W-1:0]   r_dv_rem [DIV_N+1];
    logic [NUM_W-1:0]   r_dv_nq  [DIV_N+1];
    logic signed [SUM_W-1:0] n5_n;
    t_side                   n5_sd;
    assign n5_n = w_m_neg ? -r4_n : r4_n;
    always_comb begin
        n5_sd     = r4_sd;
        n5_sd.neg = n5_n[SUM_W-1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_dv_vld[0] <= 1'b0;
        else if (w_en) r_dv_vld[0] <= r4_vld;
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dv_sd[0]  <= n5_sd;
            r_dv_rem[0] <= '0;
            r_dv_nq[0]  <= n5_n[NUM_W-1:0];
        end
    end

    // ---------------- restoring divider, one bit per stage ----------------
    for (genvar k = 0; k < DIV_N; k++) begin : g_div
        logic [REM_W:0]   n_sh;
        logic             n_bit;
        logic [REM_W-1:0] n_rem;
        assign n_sh  = {r_dv_rem[k], r_dv_nq[k][NUM_W-1]};
        assign n_bit = (n_sh >= {1'b0, w_m_mag});
        assign n_rem = n_bit ? REM_W'(n_sh - {1'b0, w_m_mag}) : n_sh[REM_W-1:0];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_dv_vld[k+1] <= 1'b0;
            else if (w_en) r_dv_vld[k+1] <= r_dv_vld[k];
        end
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_dv_sd[k+1]  <= r_dv_sd[k];
                r_dv_rem[k+1] <= n_rem;
                r_dv_nq[k+1]  <= {r_dv_nq[k][NUM_W-2:0], n_bit};
            end
        end
    end

    // ---------------- square root, one root bit per stage ----------------
    logic              r_sq_vld  [1:SQR_N];
    t_side             r_sq_sd   [1:SQR_N];
    logic [NUM_W-1:0]  r_sq_rad  [1:SQR_N];
    logic [SRM_W-1:0]  r_sq_rem  [1:SQR_N];
    logic [ROOT_W-1:0] r_sq_root [1:SQR_N];

    for (genvar k = 0; k < SQR_N; k++) begin : g_sqrt
        logic              w_vld;
        t_side             w_sd;
        logic [NUM_W-1:0]  w_rad;
        logic [SRM_W-1:0]  w_rem;
        logic [ROOT_W-1:0] w_root;
        logic [SRM_W+1:0]  n_sh;
        logic [SRM_W+1:0]  n_trial;
        logic              n_bit;

        if (k == 0) begin : g_head
            // entry of the root chain is the last divider register
            assign w_vld  = r_dv_vld[DIV_N];
            assign w_sd   = r_dv_sd[DIV_N];
            assign w_rad  = r_dv_nq[DIV_N];
            assign w_rem  = '0;
            assign w_root = '0;
        end else begin : g_link
            assign w_vld  = r_sq_vld[k];
            assign w_sd   = r_sq_sd[k];
            assign w_rad  = r_sq_rad[k];
            assign w_rem  = r_sq_rem[k];
            assign w_root = r_sq_root[k];
        end

        assign n_sh    = {w_rem, w_rad[NUM_W-1:NUM_W-2]};
        assign n_trial = {2'b00, w_root, 2'b01};
        assign n_bit   = (n_sh >= n_trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_sq_vld[k+1] <= 1'b0;
            else if (w_en) r_sq_vld[k+1] <= w_vld;
        end
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_sq_sd[k+1]   <= w_sd;
                r_sq_rad[k+1]  <= {w_rad[NUM_W-3:0], 2'b00};
                r_sq_rem[k+1]  <= n_bit ? SRM_W'(n_sh - n_trial) : n_sh[SRM_W-1:0];
                r_sq_root[k+1] <= {w_root[ROOT_W-2:0], n_bit};
            end
        end
    end

    // ---------------- root select ----------------
    logic                  r6_vld;
    logic                  r6_neg;
    logic signed [P_W-1:0] r6_p;
    logic signed [P_W-1:0] n6_s, n6_up, n6_dn, n6_p;
    logic                  n6_up_neg, n6_dn_neg, n6_plus;
    logic                  w_a1_neg;

    assign w_a1_neg  = r_accel_second[DW-1];
    assign n6_s      = $signed({3'b000, r_sq_root[SQR_N]});
    assign n6_up     = P_W'(r_sq_sd[SQR_N].v1) + n6_s;
    assign n6_dn     = P_W'(r_sq_sd[SQR_N].v1) - n6_s;
    // root (v1 +/- s) / a1 is negative when the signs differ
    assign n6_up_neg = (n6_up != '0) && (n6_up[P_W-1] != w_a1_neg);
    assign n6_dn_neg = (n6_dn != '0) && (n6_dn[P_W-1] != w_a1_neg);
    assign n6_plus   = n6_up_neg ? 1'b0 : (n6_dn_neg ? 1'b1 : w_a1_neg);
    assign n6_p      = n6_plus ? P_W'(r_sq_sd[SQR_N].v0) + n6_s
                               : P_W'(r_sq_sd[SQR_N].v0) - n6_s;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r6_vld <= 1'b0;
        else if (w_en) r6_vld <= r_sq_vld[SQR_N];
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r6_neg <= r_sq_sd[SQR_N].neg;
            r6_p   <= n6_p;
        end
    end

    // ---------------- t0 test and output register ----------------
    logic                    r_out_vld;
    logic [OUT_TDW-1:0]      r_out_data;
    logic [OUT_TUW-1:0]      r_out_user;
    logic signed [LHS_W-1:0] n7_lhs, n7_a0;
    logic                    n7_second, n7_deg;

    assign n7_lhs    = -(LHS_W'(r6_p) * LHS_W'(T0_SCALE));
    assign n7_a0     = LHS_W'(r_accel_first);
    assign n7_deg    = w_cfg_deg || r6_neg;
    assign n7_second = !n7_deg && (r_accel_first[DW-1] ? (n7_lhs > n7_a0)
                                                       : (n7_lhs < n7_a0));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_out_vld <= 1'b0;
        else if (w_en) r_out_vld <= r6_vld;
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_data <= n7_second ? r_accel_second : r_accel_first;
            r_out_user <= {n7_deg, n7_second};
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;

    // ---------------- checks ----------------
    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
        else $error("use_second and degenerate both set");

    a_second_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata == r_accel_second))
        else $error("use_second without a1 on the data");

    a_cfg_degenerate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (r_accel_first == r_accel_second)) |-> m_axis_tuser[1])
        else $error("equal accelerations not flagged degenerate");

endmodule

// ----- tb/sv/two_phase_accel_selector_test.sv -----
`timescale 1ns / 1ps
module two_phase_accel_selector_test;
    import tpas_pkg::*;

    // one result: the chosen acceleration and its two flags
    typedef struct packed {
        logic [DW-1:0] accel;
        logic          use_second;
        logic          degenerate;
    } t_choice;

    // directed row: a query, and optionally its result typed in by hand
    typedef struct {
        logic [DW-1:0] v0;
        logic [DW-1:0] v1;
        logic [DW-1:0] distance;
        bit            typed;
        t_choice       choice;
    } t_row;

    logic               i_clk;
    logic               i_rst_n;
    logic               s_axis_tvalid;
    logic               s_axis_tready;
    logic [IN_TDW-1:0]  s_axis_tdata;
    logic               m_axis_tvalid;
    logic               m_axis_tready;
    logic [OUT_TDW-1:0] m_axis_tdata;
    logic [OUT_TUW-1:0] m_axis_tuser;
    logic               i_cfg_we;
    logic [0:0]         i_cfg_idx;
    logic [DW-1:0]      i_cfg_data;

    two_phase_accel_selector dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    // our own copy of the two acceleration registers
    logic signed [DW-1:0] accel_a0;
    logic signed [DW-1:0] accel_a1;

    t_choice pending_choices[$];
    int      mismatches;
    int      results_seen;
    int      degenerate_seen;
    int      second_seen;
    int      send_idle_pct;
    int      recv_idle_pct;
    int      hold_off_cycles;

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Work out the chosen acceleration for one query, exactly, in wide integers.
    function automatic t_choice choose_accel(logic signed [DW-1:0] v0,
                                             logic signed [DW-1:0] v1,
                                             logic signed [DW-1:0] distance);
        logic signed [127:0] wa0, wa1, wv0, wv1, wd, num, den;
        logic [127:0]        quot;
        logic [63:0]         root, trial;
        logic signed [63:0]  s, sum_hi, sum_lo, p, lhs;
        bit                  plus_root, second;
        t_choice             c;
        int                  b;
        c.accel      = accel_a0;
        c.use_second = 1'b0;
        c.degenerate = 1'b1;
        // zero or equal accelerations: no profile, hold a0
        if (accel_a0 == 0 || accel_a1 == 0 || accel_a0 == accel_a1)
            return c;
        wa0 = accel_a0;
        wa1 = accel_a1;
        wv0 = v0;
        wv1 = v1;
        wd  = distance;
        num = wa1 * wv0 * wv0 - wa0 * wv1 * wv1 + wa0 * wa1 * 2 * wd;
        den = wa1 - wa0;
        if (den < 0) begin
            den = -den;
            num = -num;
        end
        // negative discriminant: no real root
        if (num < 0)
            return c;
        quot = num / den;
        root = '0;
        for (b = 63; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if ({64'd0, trial} * {64'd0, trial} <= quot)
                root = trial;
        end
        s      = root;
        sum_hi = 64'(v1) + s;
        sum_lo = 64'(v1) - s;
        // keep the smaller non-negative root; a zero root counts as non-negative
        if (sum_hi != 0 && ((sum_hi < 0) != (accel_a1 < 0)))
            plus_root = 1'b0;
        else if (sum_lo != 0 && ((sum_lo < 0) != (accel_a1 < 0)))
            plus_root = 1'b1;
        else
            plus_root = (accel_a1 < 0);
        p      = plus_root ? 64'(v0) + s : 64'(v0) - s;
        lhs    = -64'sd1000 * p;
        second = (accel_a0 > 0) ? (lhs < 64'(accel_a0)) : (lhs > 64'(accel_a0));
        c.accel      = second ? accel_a1 : accel_a0;
        c.use_second = second;
        c.degenerate = 1'b0;
        return c;
    endfunction

    // Offer one query; hold it until the transfer, then queue its result.
    task automatic offer_query(logic [DW-1:0] v0, logic [DW-1:0] v1, logic [DW-1:0] distance,
                               bit typed, t_choice typed_choice);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {distance, v1, v0};
        do @(posedge i_clk); while (!s_axis_tready);
        pending_choices.push_back(typed ? typed_choice : choose_accel(v0, v1, distance));
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
    endtask

    // Drain the pipeline, then write one register at the next edge.
    task automatic write_accel(logic [0:0] idx, logic [DW-1:0] value);
        wait (pending_choices.size() == 0);
        repeat (4) @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = value;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        if (idx == REG_ACCEL_FIRST)
            accel_a0 = value;
        else
            accel_a1 = value;
    endtask

    function automatic logic [DW-1:0] rand_field();
        case ($urandom_range(4))
            0:       return $urandom;
            1:       return $urandom_range(1, 3) << 30 | $urandom;
            2:       return 32'($signed($urandom_range(0, 32'h3ffff)) - 32'sh20000);
            default: return 32'($signed($urandom_range(0, 32'h3fffff)) - 32'sh200000);
        endcase
    endfunction

    function automatic logic [DW-1:0] rand_accel();
        case ($urandom_range(5))
            0:       return 32'h7fffffff;
            1:       return 32'h80000000;
            2:       return $urandom;
            default: return 32'($signed($urandom_range(1, 32'h7ffff)) - 32'sh40000);
        endcase
    endfunction

    // receiver: random hold-off, or a long counted stall when asked
    always @(negedge i_clk) begin
        if (hold_off_cycles > 0) begin
            hold_off_cycles <= hold_off_cycles - 1;
            m_axis_tready   <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // check every result transfer against the oldest expectation
    always @(posedge i_clk) begin
        t_choice got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = {m_axis_tdata, m_axis_tuser[0], m_axis_tuser[1]};
            results_seen++;
            if (pending_choices.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %h us=%b dg=%b", got.accel,
                             got.use_second, got.degenerate);
            end else begin
                want = pending_choices.pop_front();
                if (got.degenerate)
                    degenerate_seen++;
                if (got.use_second)
                    second_seen++;
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result %0d: expected %h us=%b dg=%b, got %h us=%b dg=%b",
                                 results_seen, want.accel, want.use_second, want.degenerate,
                                 got.accel, got.use_second, got.degenerate);
                end
            end
        end
    end

    initial begin
        #20ms;
        $display("Mismatches found");
        $finish;
    end

    initial begin
        t_row    rows[$];
        t_choice pick_a0, pick_a1, hold_a0;
        int      phase;
        int      n;
        s_axis_tvalid   = 1'b0;
        s_axis_tdata    = '0;
        m_axis_tready   = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_idx       = REG_ACCEL_FIRST;
        i_cfg_data      = '0;
        mismatches      = 0;
        results_seen    = 0;
        degenerate_seen = 0;
        second_seen     = 0;
        send_idle_pct   = 0;
        recv_idle_pct   = 0;
        hold_off_cycles = 0;
        accel_a0        = 32'h00010000;
        accel_a1        = 32'hffff0000;
        i_rst_n         = 1'b0;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        pick_a0 = '{accel: 32'h00010000, use_second: 1'b0, degenerate: 1'b0};
        pick_a1 = '{accel: 32'hffff0000, use_second: 1'b1, degenerate: 1'b0};
        hold_a0 = '{accel: 32'h00010000, use_second: 1'b0, degenerate: 1'b1};

        // after reset: standing still at the goal gives equal zero roots -> brake
        rows.push_back('{32'h0, 32'h0, 32'h0, 1, pick_a1});
        // far away at rest: accelerate first
        rows.push_back('{32'h0, 32'h0, 32'h00640000, 1, pick_a0});
        // extremes of every field
        rows.push_back('{32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 0, pick_a0});
        rows.push_back('{32'h80000000, 32'h80000000, 32'h80000000, 0, pick_a0});
        rows.push_back('{32'h7fffffff, 32'h80000000, 32'h0, 0, pick_a0});
        rows.push_back('{32'h80000000, 32'h7fffffff, 32'h7fffffff, 0, pick_a0});
        rows.push_back('{32'hffffffff, 32'h00000001, 32'h80000000, 0, pick_a0});
        // negative discriminant: goal speed out of reach in the distance left
        rows.push_back('{32'h0, 32'h0, 32'hff9c0000, 1, hold_a0});
        // braking case, near the goal at speed
        rows.push_back('{32'h000a0000, 32'h0, 32'h00320000, 0, pick_a0});
        rows.push_back('{32'h000a0000, 32'h0, 32'h00310000, 0, pick_a0});
        rows.push_back('{32'h000a0000, 32'h00050000, 32'h00250000, 0, pick_a0});
        rows.push_back('{32'hfff60000, 32'h00020000, 32'h00010000, 0, pick_a0});
        foreach (rows[i])
            offer_query(rows[i].v0, rows[i].v1, rows[i].distance, rows[i].typed,
                        rows[i].choice);

        // a0 = 0 and a1 = 0 and a0 = a1: always hold a0, flag degenerate
        write_accel(REG_ACCEL_FIRST, 32'h0);
        offer_query(32'h00010000, 32'h0, 32'h00100000, 1, '{32'h0, 1'b0, 1'b1});
        write_accel(REG_ACCEL_FIRST, 32'h00020000);
        write_accel(REG_ACCEL_SECOND, 32'h0);
        offer_query(32'h00010000, 32'h0, 32'h00100000, 1, '{32'h00020000, 1'b0, 1'b1});
        write_accel(REG_ACCEL_SECOND, 32'h00020000);
        offer_query(32'h00010000, 32'h0, 32'h00100000, 1, '{32'h00020000, 1'b0, 1'b1});
        // extreme accelerations
        write_accel(REG_ACCEL_FIRST, 32'h80000000);
        write_accel(REG_ACCEL_SECOND, 32'h7fffffff);
        offer_query(32'h00010000, 32'hffff0000, 32'h00040000, 0, pick_a0);
        offer_query(32'h7fffffff, 32'h80000000, 32'h7fffffff, 0, pick_a0);
        write_accel(REG_ACCEL_FIRST, 32'h7fffffff);
        write_accel(REG_ACCEL_SECOND, 32'h80000000);
        offer_query(32'h00010000, 32'hffff0000, 32'h00040000, 0, pick_a0);
        offer_query(32'h80000000, 32'h7fffffff, 32'h80000000, 0, pick_a0);

        // long receiver stall while queries keep coming: fill the pipeline
        write_accel(REG_ACCEL_FIRST, 32'h00010000);
        write_accel(REG_ACCEL_SECOND, 32'hffff0000);
        hold_off_cycles = 400;
        repeat (200)
            offer_query(rand_field(), rand_field(), rand_field(), 0, pick_a0);

        // random queries under three idling patterns, new accelerations often
        for (phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 16 : (phase == 1) ? 69 : 0;
            recv_idle_pct = (phase == 0) ? 69 : (phase == 1) ? 16 : 0;
            for (n = 0; n < 90; n++) begin
                if (n % 30 == 0) begin
                    write_accel(REG_ACCEL_FIRST, rand_accel());
                    write_accel(REG_ACCEL_SECOND, rand_accel());
                end
                offer_query(rand_field(), rand_field(), rand_field(), 0, pick_a0);
            end
        end

        // let the last results out, then run on with no traffic
        wait (pending_choices.size() == 0);
        repeat (200) @(posedge i_clk);

        $display("Covered %0d results: %0d took the braking acceleration, %0d degenerate.",
                 results_seen, second_seen, degenerate_seen);
        $display("Accelerations swept over zero, equal, extreme and random settings.");
        if (mismatches == 0 && pending_choices.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
